// ===== design/rtm_pkg.sv =====
package rtm_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);

  localparam int PEER_W   = 16;
  localparam int TAG_W    = 64;
  localparam int CNT_W    = 32;
  localparam int HANDLE_W = 32;
  localparam int BPF_W    = 16;
  localparam int STAT_W   = 2;
  localparam int STEP_W   = $clog2(CNT_W);

  localparam int IN_DATA_W  = PEER_W + TAG_W + 3 * CNT_W;
  localparam int OUT_BITS   = 1 + HANDLE_W + 1 + STAT_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [BPF_W-1:0] BPF_RESET = BPF_W'(16);

  localparam logic OP_POST   = 1'b0;
  localparam logic OP_ARRIVE = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISMATCH  = 2'd1;
  localparam logic [STAT_W-1:0] ST_DUPLICATE = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

  // classified item handed from front to back
  typedef struct packed {
    logic                is_post;
    logic [PEER_W-1:0]   peer;
    logic [TAG_W-1:0]    tag;
    logic [CNT_W-1:0]    flits;
    logic [HANDLE_W-1:0] handle;
  } job_t;

  typedef struct packed {
    logic                completed;
    logic [HANDLE_W-1:0] done_handle;
    logic                stored;
    logic [STAT_W-1:0]   status;
  } result_t;

endpackage

// ===== design/rtm_front.sv =====
module rtm_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [rtm_pkg::BPF_W-1:0]    flit_bytes,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_op,
  input  logic [rtm_pkg::IN_DATA_W-1:0] in_data,
  output logic                         job_valid,
  input  logic                         job_ready,
  output rtm_pkg::job_t                job
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_PUSH = 2'd2;

  localparam int P_LO = 0;
  localparam int T_LO = P_LO + rtm_pkg::PEER_W;
  localparam int B_LO = T_LO + rtm_pkg::TAG_W;
  localparam int F_LO = B_LO + rtm_pkg::CNT_W;
  localparam int H_LO = F_LO + rtm_pkg::CNT_W;

  logic [1:0]                       state_r, state_nxt;
  logic [rtm_pkg::STEP_W-1:0]       step_r, step_nxt;
  logic                             is_post_r, is_post_nxt;
  logic [rtm_pkg::PEER_W-1:0]       peer_r, peer_nxt;
  logic [rtm_pkg::TAG_W-1:0]        tag_r, tag_nxt;
  logic [rtm_pkg::HANDLE_W-1:0]     handle_r, handle_nxt;
  logic [rtm_pkg::CNT_W-1:0]        quo_r, quo_nxt;
  logic [rtm_pkg::BPF_W:0]          rem_r, rem_nxt;
  logic [rtm_pkg::BPF_W-1:0]        dsr_r, dsr_nxt;
  logic                             round_r, round_nxt;

  logic [rtm_pkg::PEER_W-1:0]       f_peer;
  logic [rtm_pkg::TAG_W-1:0]        f_tag;
  logic [rtm_pkg::CNT_W-1:0]        f_bytes;
  logic [rtm_pkg::CNT_W-1:0]        f_flits;
  logic [rtm_pkg::HANDLE_W-1:0]     f_handle;
  logic [rtm_pkg::BPF_W:0]          rem_sh;
  logic [rtm_pkg::BPF_W+1:0]        diff;
  logic                             ge;

  assign f_peer   = in_data[T_LO-1:P_LO];
  assign f_tag    = in_data[B_LO-1:T_LO];
  assign f_bytes  = in_data[F_LO-1:B_LO];
  assign f_flits  = in_data[H_LO-1:F_LO];
  assign f_handle = in_data[H_LO+rtm_pkg::HANDLE_W-1:H_LO];

  // one restoring step per cycle, quotient shifts in from the bottom
  assign rem_sh = {rem_r[rtm_pkg::BPF_W-1:0], quo_r[rtm_pkg::CNT_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dsr_r};
  assign ge     = ~diff[rtm_pkg::BPF_W+1];

  assign in_ready  = (state_r == S_IDLE);
  assign job_valid = (state_r == S_PUSH);

  always_comb begin
    job.is_post = is_post_r;
    job.peer    = peer_r;
    job.tag     = tag_r;
    job.flits   = quo_r + {{(rtm_pkg::CNT_W-1){1'b0}}, round_r};
    job.handle  = handle_r;
  end

  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    is_post_nxt = is_post_r;
    peer_nxt    = peer_r;
    tag_nxt     = tag_r;
    handle_nxt  = handle_r;
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    dsr_nxt     = dsr_r;
    round_nxt   = round_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          is_post_nxt = (in_op == rtm_pkg::OP_POST);
          peer_nxt    = f_peer;
          tag_nxt     = f_tag;
          handle_nxt  = (in_op == rtm_pkg::OP_POST) ? f_handle : '0;
          dsr_nxt     = flit_bytes;
          rem_nxt     = '0;
          round_nxt   = 1'b0;
          step_nxt    = '0;
          state_nxt   = S_PUSH;
          if (in_op == rtm_pkg::OP_ARRIVE) begin
            quo_nxt = f_flits;
          end else if (f_bytes == '0) begin
            quo_nxt = rtm_pkg::CNT_W'(1);
          end else if (flit_bytes == '0) begin
            quo_nxt = '1;
          end else begin
            quo_nxt   = f_bytes;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        rem_nxt  = ge ? diff[rtm_pkg::BPF_W:0] : rem_sh;
        quo_nxt  = {quo_r[rtm_pkg::CNT_W-2:0], ge};
        step_nxt = step_r + 1'b1;
        if (step_r == rtm_pkg::STEP_W'(rtm_pkg::CNT_W - 1)) begin
          // nonzero remainder rounds the quotient up
          round_nxt = (rem_nxt != '0);
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (job_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    step_r    <= step_nxt;
    is_post_r <= is_post_nxt;
    peer_r    <= peer_nxt;
    tag_r     <= tag_nxt;
    handle_r  <= handle_nxt;
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    dsr_r     <= dsr_nxt;
    round_r   <= round_nxt;
  end

endmodule

// ===== design/rtm_queue.sv =====
module rtm_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  rtm_pkg::job_t push_job,
  output logic          pop_valid,
  input  logic          pop_ready,
  output rtm_pkg::job_t pop_job
);

  rtm_pkg::job_t                slot_r [rtm_pkg::QUEUE_DEPTH];
  logic [rtm_pkg::QPTR_W-1:0]   wr_r, wr_nxt;
  logic [rtm_pkg::QPTR_W-1:0]   rd_r, rd_nxt;
  logic [rtm_pkg::QPTR_W:0]     count_r, count_nxt;
  logic                         do_push, do_pop;

  assign push_ready = (count_r != (rtm_pkg::QPTR_W+1)'(rtm_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = slot_r[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_nxt    = do_push ? wr_r + 1'b1 : wr_r;
    rd_nxt    = do_pop ? rd_r + 1'b1 : rd_r;
    count_nxt = count_r + {{rtm_pkg::QPTR_W{1'b0}}, do_push}
                        - {{rtm_pkg::QPTR_W{1'b0}}, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
    if (do_push) begin
      slot_r[wr_r] <= push_job;
    end
  end

endmodule

// ===== design/rtm_back.sv =====
module rtm_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             job_valid,
  output logic             job_ready,
  input  rtm_pkg::job_t    job,
  output logic             res_valid,
  input  logic             res_ready,
  output rtm_pkg::result_t res
);

  logic                          valid_r [rtm_pkg::TABLE_DEPTH];
  logic                          is_post_r [rtm_pkg::TABLE_DEPTH];
  logic [rtm_pkg::PEER_W-1:0]    peer_r [rtm_pkg::TABLE_DEPTH];
  logic [rtm_pkg::TAG_W-1:0]     tag_r [rtm_pkg::TABLE_DEPTH];
  logic [rtm_pkg::CNT_W-1:0]     flits_r [rtm_pkg::TABLE_DEPTH];
  logic [rtm_pkg::HANDLE_W-1:0]  handle_r [rtm_pkg::TABLE_DEPTH];

  logic                          res_valid_r, res_valid_nxt;
  rtm_pkg::result_t              res_r, res_nxt;

  logic [rtm_pkg::TABLE_DEPTH-1:0] hit_opp, hit_same;
  logic                            any_opp, any_same, any_free;
  logic [rtm_pkg::CNT_W-1:0]       m_flits;
  logic [rtm_pkg::HANDLE_W-1:0]    m_handle;
  logic [rtm_pkg::IDX_W-1:0]       free_idx;
  logic                            take, do_store;

  assign take      = job_valid && (!res_valid_r || res_ready);
  assign job_ready = !res_valid_r || res_ready;
  assign res_valid = res_valid_r;
  assign res       = res_r;

  // parallel key compare against every entry
  always_comb begin
    for (int i = 0; i < rtm_pkg::TABLE_DEPTH; i++) begin
      hit_opp[i]  = valid_r[i] && (is_post_r[i] != job.is_post) &&
                    (peer_r[i] == job.peer) && (tag_r[i] == job.tag);
      hit_same[i] = valid_r[i] && (is_post_r[i] == job.is_post) &&
                    (peer_r[i] == job.peer) && (tag_r[i] == job.tag);
    end
  end

  // a key is held at most once per role, so the opposite hit is one-hot
  always_comb begin
    m_flits  = '0;
    m_handle = '0;
    for (int i = 0; i < rtm_pkg::TABLE_DEPTH; i++) begin
      m_flits  = m_flits  | (flits_r[i]  & {rtm_pkg::CNT_W{hit_opp[i]}});
      m_handle = m_handle | (handle_r[i] & {rtm_pkg::HANDLE_W{hit_opp[i]}});
    end
  end

  // lowest-numbered free entry
  always_comb begin
    free_idx = '0;
    any_free = 1'b0;
    for (int i = rtm_pkg::TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = rtm_pkg::IDX_W'(i);
        any_free = 1'b1;
      end
    end
  end

  assign any_opp  = |hit_opp;
  assign any_same = |hit_same;
  assign do_store = take && !any_opp && !any_same && any_free;

  always_comb begin
    res_valid_nxt = res_valid_r;
    res_nxt       = res_r;
    if (res_valid_r && res_ready) begin
      res_valid_nxt = 1'b0;
    end
    if (take) begin
      res_valid_nxt         = 1'b1;
      res_nxt.completed     = 1'b0;
      res_nxt.done_handle   = '0;
      res_nxt.stored        = 1'b0;
      res_nxt.status        = rtm_pkg::ST_OK;
      priority if (any_opp) begin
        res_nxt.completed   = 1'b1;
        res_nxt.done_handle = job.is_post ? job.handle : m_handle;
        res_nxt.status      = (m_flits != job.flits) ? rtm_pkg::ST_MISMATCH
                                                     : rtm_pkg::ST_OK;
      end else if (any_same) begin
        res_nxt.status      = rtm_pkg::ST_DUPLICATE;
      end else if (!any_free) begin
        res_nxt.status      = rtm_pkg::ST_FULL;
      end else begin
        res_nxt.stored      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
      for (int i = 0; i < rtm_pkg::TABLE_DEPTH; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else begin
      res_valid_r <= res_valid_nxt;
      for (int i = 0; i < rtm_pkg::TABLE_DEPTH; i++) begin
        if (take && hit_opp[i]) begin
          valid_r[i] <= 1'b0;
        end else if (do_store && (free_idx == rtm_pkg::IDX_W'(i))) begin
          valid_r[i] <= 1'b1;
        end
      end
    end
    res_r <= res_nxt;
    for (int i = 0; i < rtm_pkg::TABLE_DEPTH; i++) begin
      if (do_store && (free_idx == rtm_pkg::IDX_W'(i))) begin
        is_post_r[i] <= job.is_post;
        peer_r[i]    <= job.peer;
        tag_r[i]     <= job.tag;
        flits_r[i]   <= job.flits;
        handle_r[i]  <= job.handle;
      end
    end
  end

endmodule

// ===== design/receive_tag_matcher_core.sv =====
// channel   direction  handshake             payload
// in_       slave      in_tvalid/in_tready   tdata 176 b, tuser op
// out_      master     out_tvalid/out_tready tdata 40 b
// cfg_      slave      cfg_valid/cfg_ready   flit size in bytes, 16 b
//
// a post with nonzero byte count and flit size goes through the front in order:
// accept, 32 steps of the bit-serial ceiling divider, hand-off to the queue
// other items skip the divider; the back settles one item per cycle unless results stall
// synchronous active-low reset empties the table and queue and loads a flit size of 16
// the two-entry queue and the output register let the front keep dividing while
// the result side is stalled
module receive_tag_matcher_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // input items
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [rtm_pkg::IN_DATA_W-1:0] in_tdata,  // peer, tag, byte_count, flit_count, handle
  input  logic                          in_tuser,  // op
  // results
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [rtm_pkg::OUT_DATA_W-1:0] out_tdata, // completed, done_handle, stored, status, pad
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rtm_pkg::BPF_W-1:0]     cfg_data
);

  // flit size register, to be written only while idle; the block itself does not enforce this
  logic [rtm_pkg::BPF_W-1:0] bpf_r, bpf_nxt;

  logic             f_valid, f_ready;
  rtm_pkg::job_t    f_job;
  logic             b_valid, b_ready;
  rtm_pkg::job_t    b_job;
  rtm_pkg::result_t res;

  assign cfg_ready = 1'b1;
  assign bpf_nxt   = (cfg_valid && cfg_ready) ? cfg_data : bpf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpf_r <= rtm_pkg::BPF_RESET;
    end else begin
      bpf_r <= bpf_nxt;
    end
  end

  // front: takes items, converts post sizes to flits
  rtm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .flit_bytes (bpf_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_op      (in_tuser),
    .in_data    (in_tdata),
    .job_valid  (f_valid),
    .job_ready  (f_ready),
    .job        (f_job)
  );

  // decoupling queue between front and back
  rtm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_job   (f_job),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_job    (b_job)
  );

  // back: table match, update and result register
  rtm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (b_valid),
    .job_ready (b_ready),
    .job       (b_job),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  // pack lowest field first
  assign out_tdata = {{(rtm_pkg::OUT_DATA_W - rtm_pkg::OUT_BITS){1'b0}},
                      res.status, res.stored, res.done_handle, res.completed};

endmodule
